FILE: rtl/bds_pkg.sv
// Shared types and constants of the ARGB box downsampler.
package bds_pkg;

  // Sizing
  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_SCALE_LOG2 = 3;
  localparam int ADDR_W         = $clog2(MAX_WIDTH);
  localparam int EWID_W         = ADDR_W + 1;
  localparam int CNT_W          = MAX_SCALE_LOG2;
  localparam int HSUM_W         = 8 + MAX_SCALE_LOG2;
  localparam int BSUM_W         = 8 + 2 * MAX_SCALE_LOG2;
  localparam int LANES          = 4;

  // Register fields
  localparam int SCALE_W  = 2;
  localparam int IMGW_W   = 11;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_ALPHA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_LOG2  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd2;

  // Lane order in the line store word
  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;
  localparam int LANE_ALPHA = 3;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] in_alpha;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } bds_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       row_end;
  } bds_out_t;

  // Controls for the accept cycle
  typedef struct packed {
    logic accept;
    logic cib_zero;
  } s0_ctl_t;

  // Controls for the accumulate stage
  typedef struct packed {
    logic               valid;
    logic               wr;
    logic               emit;
    logic               row_end;
    logic               rib0;
    logic               fwd_sel;
    logic [SCALE_W-1:0] sc;
    logic [ADDR_W-1:0]  bc;
  } s1_ctl_t;

endpackage

FILE: rtl/bds_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/bds_lane.sv
// One color lane: horizontal accumulate, block accumulate and average shift.
module bds_lane
  import bds_pkg::*;
(
  input  logic              clk,
  input  s0_ctl_t           s0,
  input  s1_ctl_t           s1,
  input  logic              s1_adv,
  input  logic [7:0]        px,
  input  logic [BSUM_W-1:0] rd_sum,
  output logic [BSUM_W-1:0] wr_sum,
  output logic [7:0]        avg
);

  logic [HSUM_W-1:0] hsum_r, hsum_nxt;
  logic [BSUM_W-1:0] fwd_r, fwd_nxt;
  logic [BSUM_W-1:0] base;
  logic [2:0]        shamt;

  // Restart the horizontal sum on the first column of a block
  always_comb begin
    hsum_nxt = hsum_r;
    if (s0.accept) begin
      hsum_nxt = (s0.cib_zero ? '0 : hsum_r) + HSUM_W'(px);
    end
  end

  // Add the stored column-block sum, or the one just written by the previous transfer; zero on a block's first row
  always_comb begin
    base = s1.fwd_sel ? fwd_r : rd_sum;
    if (s1.rib0) begin
      base = '0;
    end
    wr_sum = base + BSUM_W'(hsum_r);
  end

  // Hold the sum of the last advancing stage for forwarding
  always_comb begin
    fwd_nxt = fwd_r;
    if (s1.valid && s1_adv) begin
      fwd_nxt = wr_sum;
    end
  end

  // Divide by the block size
  assign shamt = {1'b0, s1.sc} << 1;
  assign avg   = 8'(wr_sum >> shamt);

  always_ff @(posedge clk) begin
    hsum_r <= hsum_nxt;
    fwd_r  <= fwd_nxt;
  end

endmodule

FILE: rtl/bds_ctrl.sv
// Raster counters, block address generation and accumulate-stage control.
module bds_ctrl
  import bds_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               frame_start,
  input  logic               s1_adv,
  input  logic [SCALE_W-1:0] scale_cfg,
  input  logic [IMGW_W-1:0]  width_cfg,
  output s0_ctl_t            s0,
  output s1_ctl_t            s1,
  output logic [ADDR_W-1:0]  raddr
);

  logic [ADDR_W-1:0]  cc_r, cc_nxt;
  logic [CNT_W-1:0]   rib_r, rib_nxt;
  logic [CNT_W-1:0]   cib_r, cib_nxt;
  s1_ctl_t            s1_r, s1_nxt;

  logic [SCALE_W-1:0] sc_eff;
  logic [CNT_W-1:0]   last;
  logic [EWID_W-1:0]  eff_w;
  logic [ADDR_W-1:0]  wm1;
  logic [ADDR_W-1:0]  cc_e, cc_c;
  logic [CNT_W-1:0]   rib_e, cib_e;
  logic               last_col, col_close, row_close;
  logic [ADDR_W-1:0]  bc;

  // Decode the configuration and the current position
  always_comb begin
    sc_eff = (32'(scale_cfg) > MAX_SCALE_LOG2) ? SCALE_W'(MAX_SCALE_LOG2) : scale_cfg;
    last   = CNT_W'((1 << sc_eff) - 1);
    if (width_cfg == '0 || 32'(width_cfg) > MAX_WIDTH) begin
      eff_w = EWID_W'(MAX_WIDTH);
    end else begin
      eff_w = EWID_W'(width_cfg);
    end
    wm1 = ADDR_W'(eff_w - EWID_W'(1));

    cc_e  = frame_start ? '0 : cc_r;
    rib_e = frame_start ? '0 : rib_r;
    cib_e = frame_start ? '0 : cib_r;

    cc_c      = (cc_e >= wm1) ? wm1 : cc_e;
    last_col  = (cc_c == wm1);
    col_close = (cib_e >= last);
    row_close = (rib_e >= last);
    bc        = cc_c >> sc_eff;
  end

  assign raddr       = bc;
  assign s0.accept   = in_fire;
  assign s0.cib_zero = (cib_e == '0);

  // Advance the raster counters
  always_comb begin
    cc_nxt  = cc_r;
    rib_nxt = rib_r;
    cib_nxt = cib_r;
    if (in_fire) begin
      cib_nxt = (col_close || last_col) ? '0 : cib_e + CNT_W'(1);
      cc_nxt  = last_col ? '0 : cc_c + ADDR_W'(1);
      rib_nxt = rib_e;
      if (last_col) begin
        rib_nxt = row_close ? '0 : rib_e + CNT_W'(1);
      end
    end
  end

  // Load the accumulate stage on a transfer, drop it when it drains
  always_comb begin
    s1_nxt = s1_r;
    if (in_fire) begin
      s1_nxt.valid   = 1'b1;
      s1_nxt.wr      = col_close;
      s1_nxt.emit    = col_close && row_close;
      s1_nxt.row_end = last_col;
      s1_nxt.rib0    = (rib_e == '0);
      s1_nxt.fwd_sel = s1_r.valid && s1_r.wr && (s1_r.bc == bc);
      s1_nxt.sc      = sc_eff;
      s1_nxt.bc      = bc;
    end else if (s1_adv) begin
      s1_nxt.valid = 1'b0;
    end
  end

  assign s1 = s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r  <= '0;
      rib_r <= '0;
      cib_r <= '0;
      s1_r  <= '0;
    end else begin
      cc_r  <= cc_nxt;
      rib_r <= rib_nxt;
      cib_r <= cib_nxt;
      s1_r  <= s1_nxt;
    end
  end

endmodule

FILE: rtl/argb_box_downsampler_unit.sv
// Top level of the ARGB box downsampler: config registers, lanes, line store, output stage.
//
// Usage:
//   in_valid/in_ready/in_data carry one ARGB pixel per transfer in raster order;
//   in_data.frame_start marks the first pixel of an image and restarts all counters.
//   out_valid/out_ready/out_data carry one RGBA pixel per factor-by-factor block,
//   produced when the bottom-right pixel of the block is taken; out_data.row_end
//   flags the last block of an output row. Factor is 1 << scale_log2.
//   cfg_we/cfg_index/cfg_data write keep_alpha (0), scale_log2 (1), image_width (2);
//   write them only while no pixel is in flight.
// Path: the pixel that closes a block passes the accumulate stage register (line-store read
//   on the transfer, sum in that stage), then the output register that drives out_valid.
// Throughput: 1 pixel per cycle while in_ready is high; the line-store read-modify-write is bypassed
//   when back-to-back pixels close the same column block.
// Reset: synchronous, active low; counters and the pipeline empty, keep_alpha 0,
//   scale_log2 0, image_width 1024. The line store is not cleared; the first row
//   of each block row writes it before it is read.
// Stall: a waiting result sits in the output register; pixels that close no block
//   keep flowing, and in_ready drops once a closing pixel waits in the accumulate stage.
module argb_box_downsampler_unit
  import bds_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bds_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bds_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic               keep_alpha_r, keep_alpha_nxt;
  logic [SCALE_W-1:0] scale_r, scale_nxt;
  logic [IMGW_W-1:0]  width_r, width_nxt;

  logic                    out_valid_r, out_valid_nxt;
  bds_out_t                out_data_r, out_data_nxt;

  logic                    in_fire;
  logic                    s1_adv;
  s0_ctl_t                 s0;
  s1_ctl_t                 s1;
  logic [ADDR_W-1:0]       raddr;
  logic                    ram_we;
  logic [LANES*BSUM_W-1:0] ram_rdata, ram_wdata;
  logic [7:0]              px  [LANES];
  logic [7:0]              avg [LANES];

  // Configuration writes
  always_comb begin
    keep_alpha_nxt = keep_alpha_r;
    scale_nxt      = scale_r;
    width_nxt      = width_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_KEEP_ALPHA:  keep_alpha_nxt = cfg_data[0];
        REG_SCALE_LOG2:  scale_nxt      = cfg_data[SCALE_W-1:0];
        REG_IMAGE_WIDTH: width_nxt      = cfg_data[IMGW_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage advances unless it holds a result and the output register is blocked
  assign s1_adv   = !s1.valid || !s1.emit || !out_valid_r || out_ready;
  assign in_ready = s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign ram_we   = s1.valid && s1.wr && s1_adv;

  bds_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .frame_start (in_data.frame_start),
    .s1_adv      (s1_adv),
    .scale_cfg   (scale_r),
    .width_cfg   (width_r),
    .s0          (s0),
    .s1          (s1),
    .raddr       (raddr)
  );

  bds_ram #(
    .WIDTH (LANES * BSUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1.bc),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // Reorder ARGB to RGBA and force alpha when not kept
  assign px[LANE_RED]   = in_data.in_red;
  assign px[LANE_GREEN] = in_data.in_green;
  assign px[LANE_BLUE]  = in_data.in_blue;
  assign px[LANE_ALPHA] = keep_alpha_r ? in_data.in_alpha : ALPHA_OPAQUE;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bds_lane u_lane (
      .clk    (clk),
      .s0     (s0),
      .s1     (s1),
      .s1_adv (s1_adv),
      .px     (px[g]),
      .rd_sum (ram_rdata[g*BSUM_W +: BSUM_W]),
      .wr_sum (ram_wdata[g*BSUM_W +: BSUM_W]),
      .avg    (avg[g])
    );
  end

  // Merge the lanes into the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1.valid && s1.emit && s1_adv) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.out_red   = avg[LANE_RED];
      out_data_nxt.out_green = avg[LANE_GREEN];
      out_data_nxt.out_blue  = avg[LANE_BLUE];
      out_data_nxt.out_alpha = avg[LANE_ALPHA];
      out_data_nxt.row_end   = s1.row_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_alpha_r <= 1'b0;
      scale_r      <= '0;
      width_r      <= IMGW_W'(MAX_WIDTH);
      out_valid_r  <= 1'b0;
    end else begin
      keep_alpha_r <= keep_alpha_nxt;
      scale_r      <= scale_nxt;
      width_r      <= width_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // An empty output register never blocks the input
  ap_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output register");

  // A new result comes only from an emitting accumulate stage
  ap_load_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1.valid && s1.emit))
    else $error("output loaded without a closing block");

  // A closing block always updates the line store
  ap_emit_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1.valid && s1.emit) |-> s1.wr)
    else $error("result without line store write");

  // A held accumulate stage keeps its block address
  ap_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1.valid && !s1_adv) |=> (s1.valid && $stable(s1.bc)))
    else $error("accumulate stage changed while held");

endmodule
